// File: rtl/core/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared widths, constants, lane types and the coefficient select helper for
// the pipelined sine Taylor polynomial evaluator.
// ----------------------------------------------------------------------------
package stp_pkg;

  // sample and center, signed Q4.12
  localparam int X_W    = 17;
  localparam int X_FRAC = 12;

  // sine and cosine of the center, signed Q1.14
  localparam int SC_W = 16;

  // magnitude of the offset from the center
  localparam int D_W = 17;

  // power term magnitude, unsigned Q.18
  localparam int PW     = 57;
  localparam int P_FRAC = 18;
  localparam int P_LO_W = 32;
  localparam int P_HI_W = PW - P_LO_W;

  // product widths of the split multipliers
  localparam int PD_LO_W = P_LO_W + D_W;
  localparam int PD_HI_W = P_HI_W + D_W;
  localparam int PC_LO_W = P_LO_W + SC_W;
  localparam int PC_HI_W = P_HI_W + SC_W;

  // dividend of the per-term divide, padded to whole digit groups
  localparam int QW         = 64;
  localparam int DIV_BITS   = 8;
  localparam int DIV_STAGES = QW / DIV_BITS;
  // remainder width, covers divisors up to the largest supported degree
  localparam int RW         = 5;

  // one quotient digit per divider stage, found by reciprocal multiply;
  // the shift is wide enough to be exact for any partial dividend
  localparam int DIG_W  = RW + DIV_BITS;
  localparam int RCP_SH = DIG_W + RW;
  localparam int RCP_W  = RCP_SH + 1;

  // term magnitude in Q.14 and running sum
  localparam int T_W   = PW + SC_W - P_FRAC;
  localparam int ACC_W = 64;

  // result, signed Q33.14
  localparam int OUT_W = 48;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS    = 2'd2;

  localparam logic signed [SC_W-1:0] COS_RESET = 16'sd16384;

  localparam logic [PW-1:0] P_ONE = PW'(1) << P_FRAC;
  localparam logic [PW-1:0] P_CAP = '1;

  localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // one pipeline lane between term sections
  typedef struct packed {
    logic                    valid;
    logic [D_W-1:0]          d_mag;
    logic                    d_neg;
    logic [PW-1:0]           p_mag;
    logic                    p_neg;
    logic signed [ACC_W-1:0] acc;
  } lane_t;

  // coefficient as sign and magnitude
  typedef struct packed {
    logic            neg;
    logic [SC_W-1:0] mag;
  } coef_t;

  // flow control status from the output section
  typedef struct packed {
    logic en;
    logic last_valid;
  } flow_t;

  // coefficient of term k, phase = k mod 4: sin, cos, -sin, -cos
  function automatic coef_t coef_sel(input logic [1:0] phase,
                                     input logic signed [SC_W-1:0] s,
                                     input logic signed [SC_W-1:0] c);
    coef_t r;
    logic signed [SC_W-1:0] v;
    v     = phase[0] ? c : s;
    r.neg = v[SC_W-1] ^ phase[1];
    r.mag = v[SC_W-1] ? SC_W'(-v) : SC_W'(v);
    return r;
  endfunction

endpackage

// File: rtl/core/stp_if.sv
// ----------------------------------------------------------------------------
// stp_if
// Valid/ready channel interfaces for samples, results and configuration.
// ----------------------------------------------------------------------------
interface stp_sample_if;
  import stp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] sample_x;
  modport source (output valid, output sample_x, input ready);
  modport sink (input valid, input sample_x, output ready);
endinterface

interface stp_result_if;
  import stp_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] approx_value;
  modport source (output valid, output approx_value, input ready);
  modport sink (input valid, input approx_value, output ready);
endinterface

interface stp_cfg_if;
  import stp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] value;
  modport source (output valid, output index, output value, input ready);
  modport sink (input valid, input index, input value, output ready);
endinterface

// File: rtl/core/sine_taylor_poly_eval.sv
// ----------------------------------------------------------------------------
// sine_taylor_poly_eval
// Fixed-point Taylor polynomial of sine about a configured center.
// ----------------------------------------------------------------------------
// Takes one sample word per clock when the result side does not stall and
// returns one saturated Q33.14 result per sample, in order. The pipeline is
// one entry stage, then one section per term with two stages of split
// multipliers and eight stages of long division by the term index at eight
// quotient bits each, then three stages for the last term and the output
// register. A stalled result holds the pipeline only while the stage in
// front of the output register is occupied. Center, sine and cosine are
// written over the configuration channel, which is always ready; write them
// only while no sample is in flight.
// ----------------------------------------------------------------------------
module sine_taylor_poly_eval #(
  parameter int DEGREE = 16
) (
  input  logic          clk,
  input  logic          rst,
  stp_cfg_if.sink       cfg,
  stp_sample_if.sink    samples,
  stp_result_if.source  results
);
  import stp_pkg::*;

  logic signed [X_W-1:0]  center;
  logic signed [SC_W-1:0] sin_center;
  logic signed [SC_W-1:0] cos_center;

  lane_t                  lanes [DEGREE+1];
  flow_t                  flow;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center     <= '0;
      sin_center <= '0;
      cos_center <= COS_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_CENTER) begin
        center <= $signed(cfg.value[X_W-1:0]);
      end
      if (cfg.index == CFG_SIN) begin
        sin_center <= $signed(cfg.value[SC_W-1:0]);
      end
      if (cfg.index == CFG_COS) begin
        cos_center <= $signed(cfg.value[SC_W-1:0]);
      end
    end
  end

  // entry stage
  stp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (flow.en),
    .center   (center),
    .samples  (samples),
    .lane_out (lanes[0])
  );

  // one section per power term
  for (genvar j = 1; j <= DEGREE; j++) begin : g_term
    stp_term #(
      .J (j)
    ) u_term (
      .clk        (clk),
      .rst        (rst),
      .en         (flow.en),
      .sin_center (sin_center),
      .cos_center (cos_center),
      .lane_in    (lanes[j-1]),
      .lane_out   (lanes[j])
    );
  end

  // last term, saturation, output register
  stp_tail #(
    .TERM (DEGREE)
  ) u_tail (
    .clk        (clk),
    .rst        (rst),
    .sin_center (sin_center),
    .cos_center (cos_center),
    .lane_in    (lanes[DEGREE]),
    .results    (results),
    .flow       (flow)
  );

  // a stall freezes the last term section
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(flow.en) |-> $stable(lanes[DEGREE].valid))
    else $error("term section moved during a stall");

  // a waiting result with a word behind it blocks new samples
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready && flow.last_valid |-> !samples.ready)
    else $error("sample taken while the output path is full");

  // configuration comes out of reset at its defaults
  a_cfg_reset: assert property (@(posedge clk)
    $past(rst) |-> center == '0 && sin_center == '0 && cos_center == COS_RESET)
    else $error("configuration not at reset values");

endmodule

// File: rtl/core/stp_front.sv
// ----------------------------------------------------------------------------
// stp_front
// Entry stage: takes a sample word, forms the offset from the center as sign
// and magnitude, and seeds the power term and the running sum.
// ----------------------------------------------------------------------------
module stp_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic signed [stp_pkg::X_W-1:0]  center,
  stp_sample_if.sink                      samples,
  output stp_pkg::lane_t                  lane_out
);
  import stp_pkg::*;

  logic signed [D_W:0] diff;
  logic                f_valid;
  logic [D_W-1:0]      f_d_mag;
  logic                f_d_neg;

  // pipeline moves as a whole
  assign samples.ready = en;

  // offset from the expansion point, exact in one extra bit
  assign diff = (D_W+1)'(samples.sample_x) - (D_W+1)'(center);

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (en) begin
      f_valid <= samples.valid;
    end
  end

  // sign and magnitude of the offset
  always_ff @(posedge clk) begin
    if (en) begin
      f_d_neg <= diff[D_W];
      f_d_mag <= diff[D_W] ? D_W'(-diff) : D_W'(diff);
    end
  end

  // power term starts at one, sum starts at zero
  always_comb begin
    lane_out.valid = f_valid;
    lane_out.d_mag = f_d_mag;
    lane_out.d_neg = f_d_neg;
    lane_out.p_mag = P_ONE;
    lane_out.p_neg = 1'b0;
    lane_out.acc   = '0;
  end

endmodule

// File: rtl/core/stp_term.sv
// ----------------------------------------------------------------------------
// stp_term
// One term section. Adds term J-1 (power term times its coefficient) to the
// running sum and forms the next power term p * d / (4096 * J), the divide
// done as a long division of one eight-bit quotient digit per stage.
// ----------------------------------------------------------------------------
module stp_term #(
  parameter int J = 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic signed [stp_pkg::SC_W-1:0] sin_center,
  input  logic signed [stp_pkg::SC_W-1:0] cos_center,
  input  stp_pkg::lane_t                  lane_in,
  output stp_pkg::lane_t                  lane_out
);
  import stp_pkg::*;

  localparam logic [1:0]       PHASE   = 2'((J - 1) % 4);
  localparam logic [RW-1:0]    DIVISOR = RW'(J);
  localparam logic [RCP_W-1:0] RECIP   = RCP_W'(((1 << RCP_SH) + J - 1) / J);
  localparam int               LAST    = DIV_STAGES - 1;

  typedef struct packed {
    logic [QW-1:0]           q;
    logic [RW-1:0]           rem;
    logic signed [ACC_W-1:0] acc;
    logic [D_W-1:0]          d_mag;
    logic                    d_neg;
    logic                    p_neg;
  } div_st_t;

  coef_t                   cf;
  logic [P_LO_W-1:0]       p_lo;
  logic [P_HI_W-1:0]       p_hi;

  logic                    a_valid;
  logic [PD_LO_W-1:0]      a_pd_lo;
  logic [PD_HI_W-1:0]      a_pd_hi;
  logic [PC_LO_W-1:0]      a_pc_lo;
  logic [PC_HI_W-1:0]      a_pc_hi;
  logic [D_W-1:0]          a_d_mag;
  logic                    a_d_neg;
  logic                    a_p_neg;
  logic                    a_t_neg;
  logic signed [ACC_W-1:0] a_acc;

  logic                    b_valid;
  logic [QW-1:0]           b_q;
  logic [T_W-1:0]          b_t;
  logic                    b_t_neg;
  logic signed [ACC_W-1:0] b_acc;
  logic [D_W-1:0]          b_d_mag;
  logic                    b_d_neg;
  logic                    b_p_neg;

  div_st_t                 entry;
  div_st_t                 dv_src  [DIV_STAGES];
  div_st_t                 dv_next [DIV_STAGES];
  div_st_t                 dv      [DIV_STAGES];
  logic [DIV_STAGES-1:0]   dv_valid;

  assign cf   = coef_sel(PHASE, sin_center, cos_center);
  assign p_lo = lane_in.p_mag[P_LO_W-1:0];
  assign p_hi = lane_in.p_mag[PW-1:P_LO_W];

  // stage a: split products for the next power and for this term
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= lane_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pd_lo <= PD_LO_W'(p_lo) * PD_LO_W'(lane_in.d_mag);
      a_pd_hi <= PD_HI_W'(p_hi) * PD_HI_W'(lane_in.d_mag);
      a_pc_lo <= PC_LO_W'(p_lo) * PC_LO_W'(cf.mag);
      a_pc_hi <= PC_HI_W'(p_hi) * PC_HI_W'(cf.mag);
      a_d_mag <= lane_in.d_mag;
      a_d_neg <= lane_in.d_neg;
      a_p_neg <= lane_in.p_neg ^ lane_in.d_neg;
      a_t_neg <= lane_in.p_neg ^ cf.neg;
      a_acc   <= lane_in.acc;
    end
  end

  // stage b: merge partial products, drop fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_q     <= (QW'(a_pd_hi) << (P_LO_W - X_FRAC)) + QW'(a_pd_lo >> X_FRAC);
      b_t     <= (T_W'(a_pc_hi) << (P_LO_W - P_FRAC)) + T_W'(a_pc_lo >> P_FRAC);
      b_t_neg <= a_t_neg;
      b_acc   <= a_acc;
      b_d_mag <= a_d_mag;
      b_d_neg <= a_d_neg;
      b_p_neg <= a_p_neg;
    end
  end

  // divider entry, term added to the sum on the way in
  always_comb begin
    entry.q     = b_q;
    entry.rem   = '0;
    entry.acc   = b_t_neg ? b_acc - $signed(ACC_W'(b_t)) : b_acc + $signed(ACC_W'(b_t));
    entry.d_mag = b_d_mag;
    entry.d_neg = b_d_neg;
    entry.p_neg = b_p_neg;
  end

  // valid bits of the divider stages
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= '0;
    end else if (en) begin
      dv_valid <= {dv_valid[DIV_STAGES-2:0], b_valid};
    end
  end

  // divider stages: one quotient digit per stage from the remainder and the
  // next eight dividend bits, digit by reciprocal multiply, quotient shifts
  // in at the bottom
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    if (s == 0) begin : g_first
      assign dv_src[s] = entry;
    end else begin : g_rest
      assign dv_src[s] = dv[s-1];
    end

    always_comb begin
      div_st_t                cur;
      logic [DIG_W-1:0]       dig;
      logic [DIG_W+RCP_W-1:0] prod;
      logic [DIV_BITS-1:0]    qd;
      cur     = dv_src[s];
      dig     = {cur.rem, cur.q[QW-1 -: DIV_BITS]};
      prod    = (DIG_W+RCP_W)'(dig) * (DIG_W+RCP_W)'(RECIP);
      qd      = DIV_BITS'(prod >> RCP_SH);
      cur.q   = {cur.q[QW-DIV_BITS-1:0], qd};
      cur.rem = RW'(dig - DIG_W'(qd) * DIG_W'(DIVISOR));
      dv_next[s] = cur;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[s] <= dv_next[s];
      end
    end
  end

  // next power term, clamped to the power width
  always_comb begin
    lane_out.valid = dv_valid[LAST];
    lane_out.d_mag = dv[LAST].d_mag;
    lane_out.d_neg = dv[LAST].d_neg;
    lane_out.p_mag = (|dv[LAST].q[QW-1:PW]) ? P_CAP : dv[LAST].q[PW-1:0];
    lane_out.p_neg = dv[LAST].p_neg;
    lane_out.acc   = dv[LAST].acc;
  end

endmodule

// File: rtl/core/stp_tail.sv
// ----------------------------------------------------------------------------
// stp_tail
// Output section: adds the last term, saturates the sum to the result width
// and holds it in the output register. Also forms the pipeline advance.
// ----------------------------------------------------------------------------
module stp_tail #(
  parameter int TERM = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic signed [stp_pkg::SC_W-1:0] sin_center,
  input  logic signed [stp_pkg::SC_W-1:0] cos_center,
  input  stp_pkg::lane_t                  lane_in,
  stp_result_if.source                    results,
  output stp_pkg::flow_t                  flow
);
  import stp_pkg::*;

  localparam logic [1:0] PHASE = 2'(TERM % 4);

  coef_t                   cf;
  logic [P_LO_W-1:0]       p_lo;
  logic [P_HI_W-1:0]       p_hi;
  logic                    out_load;
  logic                    en;
  logic                    ovf;
  logic [OUT_W-1:0]        sat;

  logic                    a_valid;
  logic [PC_LO_W-1:0]      a_pc_lo;
  logic [PC_HI_W-1:0]      a_pc_hi;
  logic                    a_t_neg;
  logic signed [ACC_W-1:0] a_acc;

  logic                    b_valid;
  logic [T_W-1:0]          b_t;
  logic                    b_t_neg;
  logic signed [ACC_W-1:0] b_acc;

  logic                    c_valid;
  logic signed [ACC_W-1:0] c_acc;

  logic                    out_valid;
  logic [OUT_W-1:0]        out_value;

  assign cf   = coef_sel(PHASE, sin_center, cos_center);
  assign p_lo = lane_in.p_mag[P_LO_W-1:0];
  assign p_hi = lane_in.p_mag[PW-1:P_LO_W];

  // output register takes a word when empty or drained; pipeline also
  // moves when the stage in front of it holds a bubble
  assign out_load = !out_valid || results.ready;
  assign en       = out_load || !c_valid;

  // stage a: split products of the last term
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= lane_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pc_lo <= PC_LO_W'(p_lo) * PC_LO_W'(cf.mag);
      a_pc_hi <= PC_HI_W'(p_hi) * PC_HI_W'(cf.mag);
      a_t_neg <= lane_in.p_neg ^ cf.neg;
      a_acc   <= lane_in.acc;
    end
  end

  // stage b: merge partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_t     <= (T_W'(a_pc_hi) << (P_LO_W - P_FRAC)) + T_W'(a_pc_lo >> P_FRAC);
      b_t_neg <= a_t_neg;
      b_acc   <= a_acc;
    end
  end

  // stage c: final sum
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_acc <= b_t_neg ? b_acc - $signed(ACC_W'(b_t)) : b_acc + $signed(ACC_W'(b_t));
    end
  end

  // saturate to the result range
  assign ovf = c_acc[ACC_W-1:OUT_W-1] != {(ACC_W-OUT_W+1){c_acc[ACC_W-1]}};
  assign sat = ovf ? (c_acc[ACC_W-1] ? OUT_MIN : OUT_MAX) : c_acc[OUT_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && c_valid) begin
      out_value <= sat;
    end
  end

  assign results.valid        = out_valid;
  assign results.approx_value = $signed(out_value);

  always_comb begin
    flow.en         = en;
    flow.last_valid = c_valid;
  end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sine Taylor polynomial evaluator. A directed
// table covers reset values, offset and register extremes, the ignored
// register index and a dropped upper data bit; random phases then rewrite the
// center, sine and cosine between bursts of samples. Every result word is
// compared in order with a bit-exact fixed-point predictor kept in the bench.
// Both channels idle at random, and one phase holds results back long
// enough to back the pipeline up into the sample channel.
// ----------------------------------------------------------------------------
module tb_top;
  import stp_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int POLY_DEGREE    = 16;
  localparam int PIPE_LATENCY   = 10 * POLY_DEGREE + 5;
  localparam int SETTLE_CYCLES  = PIPE_LATENCY + 40;
  localparam int HOLD_CYCLES    = 600;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam int NUM_PHASES     = 8;
  localparam int PHASE_WORDS    = 110;
  localparam int PRESSURE_PHASE = 3;
  localparam int PRESSURE_WORDS = 250;

  // register index past the end of the list, writes are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [79:0] POWER_CAP = (80'(1) << 57) - 80'(1);
  localparam logic signed [63:0] SAT_HIGH = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LOW  = -(64'sd1 <<< (OUT_W - 1));

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [CFG_IDX_W-1:0]    index;
    logic [CFG_DATA_W-1:0]   value;
    logic                    known;
    logic signed [OUT_W-1:0] want;
  } stim_row_t;

  localparam int NUM_ROWS = 28;

  // directed table: known results only where they follow from d = 0 or
  // zero coefficients
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_SAMPLE, CFG_CENTER, 17'h00000, 1'b1, 48'sd0},      // reset setting
    '{ROW_SAMPLE, CFG_CENTER, 17'h00001, 1'b0, 48'sd0},
    '{ROW_SAMPLE, CFG_CENTER, 17'h0ffff, 1'b0, 48'sd0},      // top sample
    '{ROW_SAMPLE, CFG_CENTER, 17'h10000, 1'b0, 48'sd0},      // bottom sample
    '{ROW_SAMPLE, CFG_CENTER, 17'h1ffff, 1'b0, 48'sd0},
    '{ROW_CFG,    CFG_SIN,    17'h04000, 1'b0, 48'sd0},
    '{ROW_SAMPLE, CFG_CENTER, 17'h00000, 1'b1, 48'sd16384},  // d = 0 gives sine
    '{ROW_CFG,    CFG_COS,    17'h00000, 1'b0, 48'sd0},
    '{ROW_CFG,    CFG_SIN,    17'h00000, 1'b0, 48'sd0},
    '{ROW_SAMPLE, CFG_CENTER, 17'h0ffff, 1'b1, 48'sd0},      // all coefs zero
    '{ROW_SAMPLE, CFG_CENTER, 17'h10000, 1'b1, 48'sd0},
    '{ROW_CFG,    CFG_UNUSED, 17'h1ffff, 1'b0, 48'sd0},      // dropped write
    '{ROW_SAMPLE, CFG_CENTER, 17'h00000, 1'b1, 48'sd0},
    '{ROW_CFG,    CFG_CENTER, 17'h10000, 1'b0, 48'sd0},
    '{ROW_CFG,    CFG_SIN,    17'h08000, 1'b0, 48'sd0},      // -2.0
    '{ROW_CFG,    CFG_COS,    17'h08000, 1'b0, 48'sd0},
    '{ROW_SAMPLE, CFG_CENTER, 17'h0ffff, 1'b0, 48'sd0},      // largest offset
    '{ROW_SAMPLE, CFG_CENTER, 17'h10000, 1'b1, -48'sd32768},
    '{ROW_SAMPLE, CFG_CENTER, 17'h00000, 1'b0, 48'sd0},
    '{ROW_CFG,    CFG_CENTER, 17'h0ffff, 1'b0, 48'sd0},
    '{ROW_CFG,    CFG_SIN,    17'h13fff, 1'b0, 48'sd0},      // bit 16 dropped
    '{ROW_CFG,    CFG_COS,    17'h1c000, 1'b0, 48'sd0},
    '{ROW_SAMPLE, CFG_CENTER, 17'h10000, 1'b0, 48'sd0},      // most negative offset
    '{ROW_SAMPLE, CFG_CENTER, 17'h0ffff, 1'b1, 48'sd16383},
    '{ROW_CFG,    CFG_CENTER, 17'h00000, 1'b0, 48'sd0},
    '{ROW_CFG,    CFG_SIN,    17'h00000, 1'b0, 48'sd0},
    '{ROW_CFG,    CFG_COS,    17'h04000, 1'b0, 48'sd0},
    '{ROW_SAMPLE, CFG_CENTER, 17'h01000, 1'b0, 48'sd0}
  };

  logic clk;
  logic rst;

  stp_sample_if sample_ch ();
  stp_result_if result_ch ();
  stp_cfg_if    cfg_ch ();

  sine_taylor_poly_eval #(
    .DEGREE(POLY_DEGREE)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (sample_ch),
    .results (result_ch)
  );

  // bench copy of the configuration registers
  logic signed [X_W-1:0]  cur_center;
  logic signed [SC_W-1:0] cur_sin;
  logic signed [SC_W-1:0] cur_cos;

  logic signed [OUT_W-1:0] pending_values [$];
  int unsigned             mismatches;
  int unsigned             send_gap_max;
  int unsigned             recv_gap_max;
  bit                      stall_results;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

  // polynomial value for one sample under the current register setting
  function automatic logic signed [OUT_W-1:0] taylor_sine_value(
    input logic signed [X_W-1:0] x
  );
    logic signed [X_W:0]    d;
    logic                   d_neg;
    logic [X_W-1:0]         d_mag;
    logic [79:0]            power;
    logic                   power_neg;
    logic [79:0]            term;
    logic [1:0]             phase;
    logic signed [SC_W-1:0] coef;
    logic                   coef_neg;
    logic [SC_W-1:0]        coef_mag;
    logic signed [63:0]     sum;
    d         = x - cur_center;
    d_neg     = d[X_W];
    d_mag     = d_neg ? X_W'(-d) : X_W'(d);
    power     = 80'(1) << P_FRAC;
    power_neg = 1'b0;
    sum       = cur_sin;
    for (int j = 1; j <= POLY_DEGREE; j++) begin
      // coefficient order: cos, -sin, -cos, sin
      phase    = 2'(j - 1);
      coef     = phase[0] ? cur_sin : cur_cos;
      coef_neg = coef[SC_W-1] ^ (phase == 2'd1 || phase == 2'd2);
      coef_mag = coef[SC_W-1] ? SC_W'(-coef) : SC_W'(coef);
      // next power d^j / j!, truncated
      power = ((power * 80'(d_mag)) >> X_FRAC) / 80'(j);
      if (power > POWER_CAP) begin
        power = POWER_CAP;
      end
      power_neg = power_neg ^ d_neg;
      term = (power * 80'(coef_mag)) >> P_FRAC;
      if (power_neg != coef_neg) begin
        sum = sum - $signed(term[63:0]);
      end else begin
        sum = sum + $signed(term[63:0]);
      end
    end
    if (sum > SAT_HIGH) begin
      sum = SAT_HIGH;
    end
    if (sum < SAT_LOW) begin
      sum = SAT_LOW;
    end
    return sum[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    mismatches++;
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
  endtask

  // sample word at the top, bottom, at the center, near it, or anywhere
  function automatic logic [X_W-1:0] pick_sample();
    logic [X_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 17'h0ffff;
      1: v = 17'h10000;
      2: v = cur_center;
      3: v = cur_center + X_W'($urandom_range(0, 511)) - X_W'(256);
      default: v = X_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_center();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = 17'h10000;
      1: v = 17'h0ffff;
      2: v = '0;
      default: v = CFG_DATA_W'($urandom);
    endcase
    return v;
  endfunction

  // sine or cosine word, with the 16-bit extremes and stray upper bits
  function automatic logic [CFG_DATA_W-1:0] pick_trig();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 17'h04000;
      1: v = 17'h1c000;
      2: v = 17'h08000;
      3: v = 17'h07fff;
      4: v = '0;
      5: v = CFG_DATA_W'($urandom);
      default: v = CFG_DATA_W'($urandom_range(0, 32768)) - CFG_DATA_W'(16384);
    endcase
    return v;
  endfunction

  // one register write, called at a falling edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.value <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (index)
      CFG_CENTER: cur_center = value;
      CFG_SIN:    cur_sin    = value[SC_W-1:0];
      CFG_COS:    cur_cos    = value[SC_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // one sample word, called at a falling edge; the gap follows acceptance
  task automatic send_sample(input logic [X_W-1:0] x, input logic known,
                             input logic signed [OUT_W-1:0] want);
    int unsigned             gap;
    logic signed [OUT_W-1:0] expected;
    sample_ch.valid    <= 1'b1;
    sample_ch.sample_x <= x;
    do @(posedge clk); while (!sample_ch.ready);
    expected       = known ? want : taylor_sine_value(x);
    pending_values = {pending_values, expected};
    @(negedge clk);
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop offering and let every expected word come back
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    while (pending_values.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // result side: random hold-off per word, one long hold on request
  initial begin : result_side
    int unsigned hold;
    result_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (stall_results) begin
        hold          = HOLD_CYCLES;
        stall_results = 1'b0;
      end else begin
        hold = $urandom_range(0, recv_gap_max);
      end
      if (hold != 0) begin
        result_ch.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      if (pending_values.size() == 0) begin
        report_mismatch("unexpected result word", result_ch.approx_value, '0);
      end else if (result_ch.approx_value !== pending_values[0]) begin
        report_mismatch("approx_value", result_ch.approx_value, pending_values[0]);
        void'(pending_values.pop_front());
      end else begin
        void'(pending_values.pop_front());
      end
      @(negedge clk);
    end
  end

  // stimulus
  initial begin : stimulus
    int unsigned words;
    rst                = 1'b1;
    sample_ch.valid    = 1'b0;
    sample_ch.sample_x = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_CENTER;
    cfg_ch.value       = '0;
    cur_center         = '0;
    cur_sin            = '0;
    cur_cos            = COS_RESET;
    mismatches         = 0;
    send_gap_max       = 12;
    recv_gap_max       = 12;
    stall_results      = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table
    foreach (DIRECTED_ROWS[i]) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].value);
      end else begin
        send_sample(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].known,
                    DIRECTED_ROWS[i].want);
      end
    end

    // random phases, registers rewritten while idle
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      end
      write_reg(CFG_CENTER, pick_center());
      write_reg(CFG_SIN, pick_trig());
      write_reg(CFG_COS, pick_trig());
      case (ph % 3)
        0: begin
          send_gap_max = 12;
          recv_gap_max = 12;
        end
        1: begin
          send_gap_max = 0;
          recv_gap_max = 0;
        end
        default: begin
          send_gap_max = $urandom_range(0, 12);
          recv_gap_max = $urandom_range(0, 12);
        end
      endcase
      words = PHASE_WORDS;
      if (ph == PRESSURE_PHASE) begin
        // back-to-back samples against a long result hold
        send_gap_max  = 0;
        recv_gap_max  = 3;
        stall_results = 1'b1;
        words         = PRESSURE_WORDS;
      end
      repeat (words) send_sample(pick_sample(), 1'b0, '0);
    end

    // drain and watch for stray words
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sine_taylor_poly_eval.f
rtl/core/stp_pkg.sv
rtl/core/stp_if.sv
rtl/core/stp_front.sv
rtl/core/stp_term.sv
rtl/core/stp_tail.sv
rtl/core/sine_taylor_poly_eval.sv
tb/tb_top.sv
